/* rtl/direct_mapped_cache_tag_lookup_core_macros.svh */
// Assertion macros shared by the tag lookup core modules.
// Expects clk and arst_n in scope at the point of use.
`ifndef DIRECT_MAPPED_CACHE_TAG_LOOKUP_CORE_MACROS_SVH
`define DIRECT_MAPPED_CACHE_TAG_LOOKUP_CORE_MACROS_SVH

// same-cycle implication
`define DMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dmc_pkg.sv */
// Shared constants and types for the direct-mapped tag lookup core.
// No dependencies.
package dmc_pkg;

	localparam int ADDR_W      = 32;
	localparam int LINE_COUNT  = 128;
	localparam int BLOCK_BYTES = 32;
	localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
	localparam int LINE_W      = $clog2(LINE_COUNT);
	localparam int BLOCK_W     = ADDR_W - OFFSET_W;
	localparam int TAG_W       = 20;
	localparam int RD_SIZE_W   = 6;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic load_in;  // capture request, start tag read
		logic commit;   // compare, update store, load result
	} dmc_cmd_t;

endpackage

/* rtl/dmc_ctrl.sv */
// Sequencing controller for the tag lookup core: input/output handshake.
// Depends on dmc_pkg and the core macro header.
`include "direct_mapped_cache_tag_lookup_core_macros.svh"

module dmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dmc_pkg::dmc_cmd_t cmd
);
	import dmc_pkg::*;

	typedef enum logic {ST_IDLE, ST_LOOK} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || out_ready;
	assign cmd.load_in = in_valid && in_ready;
	assign cmd.commit  = (state_q == ST_LOOK) && out_free;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_in) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`DMC_ASSERT_NEXT(a_one_in_flight, cmd.load_in, !in_ready, "second beat taken during lookup")
	`DMC_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "committed result not presented")
	`DMC_ASSERT_NEXT(a_stall_holds, (state_q == ST_LOOK) && out_valid && !out_ready,
		(state_q == ST_LOOK), "lookup left while result stalled")

endmodule

/* rtl/dmc_datapath.sv */
// Datapath: request capture, tag RAM, valid bits, hit logic, result register.
// Depends on dmc_pkg and the core macro header.
`include "direct_mapped_cache_tag_lookup_core_macros.svh"

module dmc_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dmc_pkg::dmc_cmd_t                  cmd,
	input  logic [dmc_pkg::ADDR_W-1:0]         address,
	input  logic                               mode,
	output logic [dmc_pkg::OFFSET_W-1:0]       byte_offset,
	output logic [dmc_pkg::BLOCK_W-1:0]        block_number,
	output logic [dmc_pkg::LINE_W-1:0]         line_index,
	output logic [dmc_pkg::TAG_W-1:0]          tag,
	output logic                               miss,
	output logic                               memory_read,
	output logic [dmc_pkg::RD_SIZE_W-1:0]      memory_read_size,
	output logic                               memory_write,
	output logic                               memory_write_size,
	output logic                               replacement,
	output logic [dmc_pkg::TAG_W-1:0]          evicted_tag
);
	import dmc_pkg::*;

	logic [TAG_W-1:0]      tag_mem [LINE_COUNT];
	logic [LINE_COUNT-1:0] line_valid_q;

	logic [ADDR_W-1:0] addr_q;
	logic              mode_q;
	logic [TAG_W-1:0]  rd_tag_q;

	logic [OFFSET_W-1:0] cur_offset;
	logic [BLOCK_W-1:0]  cur_block;
	logic [LINE_W-1:0]   cur_line;
	logic [TAG_W-1:0]    cur_tag;
	logic [LINE_W-1:0]   in_line;
	logic                cur_valid;
	logic                hit;
	logic                is_write;
	logic                fill;

	logic [OFFSET_W-1:0]  byte_offset_q;
	logic [BLOCK_W-1:0]   block_number_q;
	logic [LINE_W-1:0]    line_index_q;
	logic [TAG_W-1:0]     tag_q;
	logic                 miss_q;
	logic                 memory_read_q;
	logic [RD_SIZE_W-1:0] memory_read_size_q;
	logic                 memory_write_q;
	logic                 memory_write_size_q;
	logic                 replacement_q;
	logic [TAG_W-1:0]     evicted_tag_q;

	assign in_line    = address[OFFSET_W +: LINE_W];
	assign cur_offset = addr_q[OFFSET_W-1:0];
	assign cur_block  = addr_q[ADDR_W-1:OFFSET_W];
	assign cur_line   = cur_block[LINE_W-1:0];
	assign cur_tag    = cur_block[LINE_W +: TAG_W];
	assign cur_valid  = line_valid_q[cur_line];
	assign hit        = cur_valid && (rd_tag_q == cur_tag);
	assign is_write   = (mode_q == MODE_WRITE);
	// read miss allocates; writes never touch the store
	assign fill       = !is_write && !hit;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			addr_q   <= address;
			mode_q   <= mode;
			rd_tag_q <= tag_mem[in_line];
		end
		if (cmd.commit && fill) tag_mem[cur_line] <= cur_tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
		end else if (cmd.commit && fill) begin
			line_valid_q[cur_line] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			byte_offset_q       <= cur_offset;
			block_number_q      <= cur_block;
			line_index_q        <= cur_line;
			tag_q               <= cur_tag;
			miss_q              <= !hit;
			memory_read_q       <= fill;
			memory_read_size_q  <= fill ? RD_SIZE_W'(BLOCK_BYTES) : '0;
			memory_write_q      <= is_write;
			memory_write_size_q <= is_write;
			replacement_q       <= fill && cur_valid;
			evicted_tag_q       <= (fill && cur_valid) ? rd_tag_q : '0;
		end
	end

	assign byte_offset       = byte_offset_q;
	assign block_number      = block_number_q;
	assign line_index        = line_index_q;
	assign tag               = tag_q;
	assign miss              = miss_q;
	assign memory_read       = memory_read_q;
	assign memory_read_size  = memory_read_size_q;
	assign memory_write      = memory_write_q;
	assign memory_write_size = memory_write_size_q;
	assign replacement       = replacement_q;
	assign evicted_tag       = evicted_tag_q;

	`DMC_ASSERT_NEXT(a_fill_sets_valid, cmd.commit && !is_write, line_valid_q[cur_line],
		"read lookup left line invalid")
	`DMC_ASSERT_NEXT(a_write_no_alloc, cmd.commit && is_write, $stable(line_valid_q),
		"write changed valid bits")
	`DMC_ASSERT_NEXT(a_read_is_miss, cmd.commit, !memory_read || (miss && !memory_write),
		"block fetch without read miss")

endmodule

/* rtl/direct_mapped_cache_tag_lookup_core.sv */
// Direct-mapped tag lookup, write-through, no write-allocate.
// Flow: the request and tag RAM read are registered at the input beat; the result register loads
// once the output is free, so results come later while one is stalled. One beat in flight: the
// compare state compares, refills the line and loads the result before a new beat is taken.
// Reset: asynchronous, clears all line valid bits at once; no clearing pass.
module direct_mapped_cache_tag_lookup_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [dmc_pkg::ADDR_W-1:0]         address,
	input  logic                               mode,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dmc_pkg::OFFSET_W-1:0]       byte_offset,
	output logic [dmc_pkg::BLOCK_W-1:0]        block_number,
	output logic [dmc_pkg::LINE_W-1:0]         line_index,
	output logic [dmc_pkg::TAG_W-1:0]          tag,
	output logic                               miss,
	output logic                               memory_read,
	output logic [dmc_pkg::RD_SIZE_W-1:0]      memory_read_size,
	output logic                               memory_write,
	output logic                               memory_write_size,
	output logic                               replacement,
	output logic [dmc_pkg::TAG_W-1:0]          evicted_tag
);
	import dmc_pkg::*;

	dmc_cmd_t cmd;

	dmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	dmc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.address           (address),
		.mode              (mode),
		.byte_offset       (byte_offset),
		.block_number      (block_number),
		.line_index        (line_index),
		.tag               (tag),
		.miss              (miss),
		.memory_read       (memory_read),
		.memory_read_size  (memory_read_size),
		.memory_write      (memory_write),
		.memory_write_size (memory_write_size),
		.replacement       (replacement),
		.evicted_tag       (evicted_tag)
	);

endmodule

/* tb/direct_mapped_cache_tag_lookup_core_tb.sv */
// Self-checking testbench for direct_mapped_cache_tag_lookup_core.
// Uses dmc_pkg for widths and mode codes; the scoreboard keeps its own tag store.
`timescale 1ns / 1ps

module direct_mapped_cache_tag_lookup_core_tb;
	import dmc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int MAX_REPORTS = 40;
	localparam int POOL_SIZE = 8;

	typedef struct packed {
		logic [OFFSET_W-1:0]  byte_offset;
		logic [BLOCK_W-1:0]   block_number;
		logic [LINE_W-1:0]    line_index;
		logic [TAG_W-1:0]     tag;
		logic                 miss;
		logic                 memory_read;
		logic [RD_SIZE_W-1:0] memory_read_size;
		logic                 memory_write;
		logic                 memory_write_size;
		logic                 replacement;
		logic [TAG_W-1:0]     evicted_tag;
	} lookup_t;

	class lookup_scoreboard;
		bit [TAG_W-1:0] line_tag [LINE_COUNT];
		bit             line_valid [LINE_COUNT];
		lookup_t        pending [$];
		int             errors;

		// Run one access through the tag store and queue its result.
		function void note_access(logic [ADDR_W-1:0] a, logic m);
			lookup_t r;
			logic [LINE_W-1:0] idx;
			logic hit;
			r = '0;
			r.byte_offset = a[OFFSET_W-1:0];
			r.block_number = a[ADDR_W-1:OFFSET_W];
			idx = r.block_number[LINE_W-1:0];
			r.line_index = idx;
			r.tag = r.block_number[BLOCK_W-1:LINE_W];
			hit = line_valid[idx] && (line_tag[idx] == r.tag);
			r.miss = !hit;
			if (m == MODE_WRITE) begin
				// write-through, never allocates
				r.memory_write = 1'b1;
				r.memory_write_size = 1'b1;
			end else if (!hit) begin
				if (line_valid[idx]) begin
					r.replacement = 1'b1;
					r.evicted_tag = line_tag[idx];
				end
				line_tag[idx] = r.tag;
				line_valid[idx] = 1'b1;
				r.memory_read = 1'b1;
				r.memory_read_size = RD_SIZE_W'(BLOCK_BYTES);
			end
			pending.push_back(r);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				flag($sformatf("%s mismatch, expected 0x%0h, actual 0x%0h", name, want, got));
		endfunction

		function void check_result(lookup_t got);
			lookup_t want;
			if (pending.size() == 0) begin
				flag($sformatf("result beat with nothing outstanding, actual %p", got));
				return;
			end
			want = pending.pop_front();
			check_field("byte_offset", want.byte_offset, got.byte_offset);
			check_field("block_number", want.block_number, got.block_number);
			check_field("line_index", want.line_index, got.line_index);
			check_field("tag", want.tag, got.tag);
			check_field("miss", want.miss, got.miss);
			check_field("memory_read", want.memory_read, got.memory_read);
			check_field("memory_read_size", want.memory_read_size, got.memory_read_size);
			check_field("memory_write", want.memory_write, got.memory_write);
			check_field("memory_write_size", want.memory_write_size, got.memory_write_size);
			check_field("replacement", want.replacement, got.replacement);
			check_field("evicted_tag", want.evicted_tag, got.evicted_tag);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [ADDR_W-1:0]    address = '0;
	logic                 mode = MODE_READ;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [OFFSET_W-1:0]  byte_offset;
	logic [BLOCK_W-1:0]   block_number;
	logic [LINE_W-1:0]    line_index;
	logic [TAG_W-1:0]     tag;
	logic                 miss;
	logic                 memory_read;
	logic [RD_SIZE_W-1:0] memory_read_size;
	logic                 memory_write;
	logic                 memory_write_size;
	logic                 replacement;
	logic [TAG_W-1:0]     evicted_tag;

	lookup_scoreboard sb = new;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off_req = 1'b0;
	int quiet_cycles = 0;
	logic [TAG_W-1:0] tag_pool [POOL_SIZE];

	direct_mapped_cache_tag_lookup_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.address(address),
		.mode(mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_offset(byte_offset),
		.block_number(block_number),
		.line_index(line_index),
		.tag(tag),
		.miss(miss),
		.memory_read(memory_read),
		.memory_read_size(memory_read_size),
		.memory_write(memory_write),
		.memory_write_size(memory_write_size),
		.replacement(replacement),
		.evicted_tag(evicted_tag)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Beat monitor: inputs are noted before results are checked at each edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_access(address, mode);
			if (out_valid && out_ready)
				sb.check_result({byte_offset, block_number, line_index, tag, miss,
					memory_read, memory_read_size, memory_write, memory_write_size,
					replacement, evicted_tag});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("[direct_mapped_cache_tag_lookup_core] ERROR");
				$finish;
			end
		end
	end

	// Result side; a hold-off request parks out_ready low for a long stretch.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_access(input logic [ADDR_W-1:0] a, input logic m);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		address <= a;
		mode <= m;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Mostly a few tags over a few lines so hits and evictions are common.
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [LINE_W-1:0] line;
		if ($urandom_range(4) == 0)
			return $urandom();
		line = ($urandom_range(3) == 0) ? LINE_W'($urandom_range(LINE_COUNT - 1))
			: LINE_W'($urandom_range(15));
		return {tag_pool[$urandom_range(POOL_SIZE - 1)], line, OFFSET_W'($urandom())};
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_access(pick_address(), ($urandom_range(2) == 0) ? MODE_WRITE : MODE_READ);
	endtask

	initial begin
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			tag_pool[i] = TAG_W'($urandom());

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 72;

		// directed: cold miss, hit, write hit/miss, evictions both ways, extremes
		send_access(32'h0000_0000, MODE_READ);
		send_access(32'h0000_001F, MODE_READ);
		send_access(32'h0000_0004, MODE_WRITE);
		send_access(32'hFFFF_FFFF, MODE_WRITE);
		send_access(32'hFFFF_FFFF, MODE_READ);
		send_access(32'hFFFF_FFE0, MODE_READ);
		send_access(32'h0000_0FE0, MODE_READ);
		send_access(32'hFFFF_FFFF, MODE_READ);
		send_access(32'h0000_1000, MODE_WRITE);
		send_access(32'h0000_1000, MODE_READ);
		send_access(32'h0000_0000, MODE_READ);
		send_access(32'h0000_1008, MODE_WRITE);
		send_access(32'hAAAA_AAAA, MODE_READ);
		send_access(32'h5555_5555, MODE_READ);
		send_access(32'hAAAA_AAAA, MODE_WRITE);
		send_access(32'h5555_5555, MODE_WRITE);
		send_access(32'h8000_0000, MODE_READ);
		send_access(32'h7FFF_FFFF, MODE_READ);
		send_access(32'h8000_0000, MODE_READ);
		send_access(32'h0000_0FFF, MODE_WRITE);

		send_random(620);

		send_idle_pct = 72;
		recv_idle_pct = 25;
		send_random(620);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req = 1'b1;
		send_random(610);

		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (sb.errors == 0)
			$display("[direct_mapped_cache_tag_lookup_core] OK");
		else
			$display("[direct_mapped_cache_tag_lookup_core] ERROR");
		$finish;
	end

endmodule
